### hw/rtl/pnl_pkg.sv
`timescale 1ns / 1ps

package pnl_pkg;

   localparam int OP_BITS   = 4;
   localparam int WORD_BITS = 64;
   localparam int MODE_BITS = 2;
   localparam int LANE_MAX  = 4;

   typedef enum logic [OP_BITS-1:0] {
      OP_AND  = 4'd0,
      OP_OR   = 4'd1,
      OP_XOR  = 4'd2,
      OP_ADD  = 4'd3,
      OP_SUB  = 4'd4,
      OP_SHL  = 4'd5,
      OP_LSHR = 4'd6,
      OP_ASHR = 4'd7,
      OP_EQ   = 4'd8,
      OP_NE   = 4'd9,
      OP_ULT  = 4'd10,
      OP_SLT  = 4'd11
   } alu_op_type;

   typedef enum logic [MODE_BITS-1:0] {
      LANE_1 = 2'd0,
      LANE_2 = 2'd1,
      LANE_4 = 2'd2
   } lane_mode_type;

   localparam logic [MODE_BITS-1:0] MODE_RESET = LANE_4;

   typedef struct packed {
      logic                hit;
      logic [LANE_MAX-1:0] value;
   } lane_res_type;

   // one lane of up to four bits; x and y arrive already masked to the lane width
   function automatic lane_res_type lane_op(input logic [OP_BITS-1:0]   op,
                                            input logic [LANE_MAX-1:0]  x,
                                            input logic [LANE_MAX-1:0]  y,
                                            input logic [MODE_BITS-1:0] mode);
      logic [LANE_MAX-1:0] lm;
      logic [LANE_MAX-1:0] hb;
      logic [2:0]          nbits;
      logic [LANE_MAX-1:0] amt;
      logic [LANE_MAX-1:0] r;
      logic                is_cmp;
      logic                c;
      lane_res_type        res;
      unique case (mode)
         LANE_1: begin
            lm    = 4'h1;
            hb    = 4'h1;
            nbits = 3'd1;
         end
         LANE_2: begin
            lm    = 4'h3;
            hb    = 4'h2;
            nbits = 3'd2;
         end
         default: begin
            lm    = 4'hf;
            hb    = 4'h8;
            nbits = 3'd4;
         end
      endcase
      amt    = '0;
      r      = '0;
      is_cmp = 1'b0;
      c      = 1'b0;
      unique case (op)
         OP_AND: r = x & y;
         OP_OR:  r = x | y;
         OP_XOR: r = x ^ y;
         OP_ADD: r = (x + y) & lm;
         OP_SUB: r = (x - y) & lm;
         OP_SHL: begin
            amt = y & {1'b0, nbits - 3'd1};
            r   = (x << amt) & lm;
         end
         OP_LSHR: begin
            amt = y & {1'b0, nbits - 3'd1};
            r   = x >> amt;
         end
         OP_ASHR: begin
            amt = (y >= {1'b0, nbits}) ? {1'b0, nbits - 3'd1} : y;
            r   = x >> amt;
            if ((x & hb) != '0) begin
               r = r | (lm & ~(lm >> amt));
            end
         end
         OP_EQ: begin
            is_cmp = 1'b1;
            c      = (x == y);
         end
         OP_NE: begin
            is_cmp = 1'b1;
            c      = (x != y);
         end
         OP_ULT: begin
            is_cmp = 1'b1;
            c      = (x < y);
         end
         OP_SLT: begin
            is_cmp = 1'b1;
            c      = ((x ^ hb) < (y ^ hb));
         end
         default: r = '0;
      endcase
      res.hit   = is_cmp & c;
      res.value = is_cmp ? (c ? lm : '0) : r;
      return res;
   endfunction

endpackage

### hw/rtl/pnl_stage.sv
`timescale 1ns / 1ps

module pnl_stage #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

### hw/rtl/pnl_alu.sv
`timescale 1ns / 1ps

module pnl_alu #(
   parameter int CARRIER_BITS = 64
) (
   input  logic [pnl_pkg::MODE_BITS-1:0] mode,
   input  logic [pnl_pkg::OP_BITS-1:0]   op,
   input  logic [pnl_pkg::WORD_BITS-1:0] operand_a,
   input  logic [pnl_pkg::WORD_BITS-1:0] operand_b,
   output logic [pnl_pkg::WORD_BITS-1:0] result_word,
   output logic [pnl_pkg::WORD_BITS-1:0] compare_bits
);

   import pnl_pkg::*;

   localparam int LANES_1 = CARRIER_BITS;
   localparam int LANES_2 = CARRIER_BITS / 2;
   localparam int LANES_4 = CARRIER_BITS / 4;

   lane_res_type lane_res;

   always_comb begin
      result_word  = '0;
      compare_bits = '0;
      lane_res     = '0;
      unique case (mode)
         LANE_1: begin
            for (int i = 0; i < LANES_1; i++) begin
               lane_res = lane_op(op, {3'b000, operand_a[i]}, {3'b000, operand_b[i]},
                                  LANE_1);
               result_word[i]  = lane_res.value[0];
               compare_bits[i] = lane_res.hit;
            end
         end
         LANE_2: begin
            for (int i = 0; i < LANES_2; i++) begin
               lane_res = lane_op(op, {2'b00, operand_a[2*i +: 2]},
                                  {2'b00, operand_b[2*i +: 2]}, LANE_2);
               result_word[2*i +: 2] = lane_res.value[1:0];
               compare_bits[i]       = lane_res.hit;
            end
         end
         default: begin
            for (int i = 0; i < LANES_4; i++) begin
               lane_res = lane_op(op, operand_a[4*i +: 4], operand_b[4*i +: 4], LANE_4);
               result_word[4*i +: 4] = lane_res.value;
               compare_bits[i]       = lane_res.hit;
            end
         end
      endcase
   end

endmodule

### hw/rtl/packed_narrow_lane_simd_alu.sv
`timescale 1ns / 1ps
// Packed narrow-lane SIMD ALU.
// Request channel (req_): one opcode in tuser and two packed operands in tdata.
// Response channel (rsp_): packed lane results and the per-lane compare mask.
// csr_ write channel sets the lane width (0: 1 bit, 1: 2 bits, 2 or 3: 4 bits);
// write it only while no request is in flight. csr_ready is always high.
// Lanes are CARRIER_BITS wide in total; bits beyond the last whole lane are zero.
// A request taken into the input register passes through the combinational lane
// datapath into the result register, from which it leaves on rsp_.
// Throughput: one request per cycle while rsp_tready stays high, set by the input
// register, the combinational lane datapath and the result register.
// A stalled response holds in the result register; the input register still
// takes one more request, after which req_tready follows rsp_tready.
// Reset empties both registers and sets 4-bit lanes.

module packed_narrow_lane_simd_alu #(
   parameter int CARRIER_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2*pnl_pkg::WORD_BITS-1:0] req_tdata, // operand_a, operand_b
   input  logic [pnl_pkg::OP_BITS-1:0]    req_tuser, // req_type
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [2*pnl_pkg::WORD_BITS-1:0] rsp_tdata, // result_word, compare_bits
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pnl_pkg::MODE_BITS-1:0]  csr_data   // lane_width_mode
);

   import pnl_pkg::*;

   localparam int IN_BITS  = OP_BITS + 2 * WORD_BITS;
   localparam int OUT_BITS = 2 * WORD_BITS;

   logic [MODE_BITS-1:0] mode_ff;
   logic [MODE_BITS-1:0] mode_in;

   logic                 s1_valid;
   logic                 s1_ready;
   logic [IN_BITS-1:0]   s1_data;
   logic [WORD_BITS-1:0] result_word;
   logic [WORD_BITS-1:0] compare_bits;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   pnl_stage #(
      .WIDTH(IN_BITS)
   ) u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ({req_tuser, req_tdata}),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   pnl_alu #(
      .CARRIER_BITS(CARRIER_BITS)
   ) u_alu (
      .mode         (mode_ff),
      .op           (s1_data[IN_BITS-1 -: OP_BITS]),
      .operand_a    (s1_data[WORD_BITS-1:0]),
      .operand_b    (s1_data[2*WORD_BITS-1:WORD_BITS]),
      .result_word  (result_word),
      .compare_bits (compare_bits)
   );

   pnl_stage #(
      .WIDTH(OUT_BITS)
   ) u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   ({compare_bits, result_word}),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

### hw/rtl/pnl_checker.sv
`timescale 1ns / 1ps

module pnl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [2*pnl_pkg::WORD_BITS-1:0] rsp_tdata
);

   import pnl_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // a true lane-0 compare must show as ones in lane 0 of the result
   a_cmp_lane0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[WORD_BITS] |-> rsp_tdata[0])
      else $error("compare mask disagrees with result word");

   // an accepted request reaches the output through the input and result registers when not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("request lost in the pipeline");

endmodule

bind packed_narrow_lane_simd_alu pnl_checker u_pnl_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pnl_pkg::*;

   localparam logic [OP_BITS-1:0]   OP_SPARE_LO = 4'd12;
   localparam logic [OP_BITS-1:0]   OP_SPARE_HI = 4'd15;
   localparam logic [MODE_BITS-1:0] MODE_SPARE  = 2'd3;
   localparam logic [63:0]          ONES        = {64{1'b1}};
   localparam logic [63:0]          ZERO        = 64'd0;
   localparam int                   CYCLE_LIMIT = 200_000;
   localparam int                   LONG_HOLD   = 300;
   localparam int                   PHASES      = 10;
   localparam int                   PHASE_OPS   = 48;

   typedef struct {
      logic [MODE_BITS-1:0] mode;
      logic [OP_BITS-1:0]   op;
      logic [63:0]          a;
      logic [63:0]          b;
      bit                   typed;
      logic [63:0]          want_word;
      logic [63:0]          want_bits;
   } lane_case_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic [3:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_data   = '0;

   logic [MODE_BITS-1:0] lane_mode = MODE_RESET;
   logic [127:0]         pending_lane_results[$];
   logic [127:0]         due_result;
   int unsigned          failures          = 0;
   int unsigned          cycle_count       = 0;
   int unsigned          sink_hold         = 0;
   bit                   sender_idles      = 1'b0;
   bit                   sink_idles        = 1'b0;
   bit                   long_hold_request = 1'b0;

   lane_case_type lane_cases [25] = '{
      '{LANE_4, OP_AND, ONES, ONES, 1'b1, ONES, ZERO},
      '{LANE_4, OP_OR, ZERO, ZERO, 1'b1, ZERO, ZERO},
      '{LANE_4, OP_XOR, 64'h0123_4567_89AB_CDEF, 64'hF0F0_0F0F_A5A5_5A5A, 1'b0, ZERO, ZERO},
      '{LANE_4, OP_ADD, ONES, 64'h1111_1111_1111_1111, 1'b1, ZERO, ZERO},
      '{LANE_4, OP_SUB, ZERO, 64'h1111_1111_1111_1111, 1'b1, ONES, ZERO},
      '{LANE_4, OP_SHL, 64'h1111_1111_1111_1111, 64'hFEDC_BA98_7654_3210, 1'b0, ZERO, ZERO},
      '{LANE_4, OP_LSHR, 64'h8888_8888_8888_8888, 64'hFEDC_BA98_7654_3210, 1'b0, ZERO, ZERO},
      '{LANE_4, OP_ASHR, 64'h8888_7777_F0F0_9A5C, 64'hFEDC_BA98_7654_3210, 1'b0, ZERO, ZERO},
      '{LANE_4, OP_EQ, 64'hDEAD_BEEF_0123_4567, 64'hDEAD_BEEF_0123_4567, 1'b1, ONES,
        64'h0000_0000_0000_FFFF},
      '{LANE_4, OP_NE, 64'hDEAD_BEEF_0123_4567, 64'hDEAD_BEEF_0123_4567, 1'b1, ZERO, ZERO},
      '{LANE_4, OP_ULT, ZERO, ONES, 1'b1, ONES, 64'h0000_0000_0000_FFFF},
      '{LANE_4, OP_SLT, 64'h8888_8888_8888_8888, 64'h7777_7777_7777_7777, 1'b1, ONES,
        64'h0000_0000_0000_FFFF},
      '{LANE_4, OP_SPARE_LO, ONES, ONES, 1'b1, ZERO, ZERO},
      '{LANE_4, OP_SPARE_HI, 64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, ZERO, ZERO},
      '{LANE_1, OP_ADD, 64'h0123_4567_89AB_CDEF, 64'hF0F0_0F0F_A5A5_5A5A, 1'b0, ZERO, ZERO},
      '{LANE_1, OP_SUB, 64'h0123_4567_89AB_CDEF, 64'hF0F0_0F0F_A5A5_5A5A, 1'b0, ZERO, ZERO},
      '{LANE_1, OP_SHL, 64'h0123_4567_89AB_CDEF, ONES, 1'b0, ZERO, ZERO},
      '{LANE_1, OP_ASHR, 64'h0123_4567_89AB_CDEF, ONES, 1'b0, ZERO, ZERO},
      '{LANE_1, OP_ULT, ZERO, ONES, 1'b1, ONES, ONES},
      '{LANE_1, OP_SLT, ONES, ZERO, 1'b1, ONES, ONES},
      '{LANE_2, OP_ADD, ONES, 64'h5555_5555_5555_5555, 1'b0, ZERO, ZERO},
      '{LANE_2, OP_ASHR, 64'hAAAA_AAAA_AAAA_AAAA, ONES, 1'b0, ZERO, ZERO},
      '{LANE_2, OP_EQ, ZERO, ZERO, 1'b1, ONES, 64'h0000_0000_FFFF_FFFF},
      '{MODE_SPARE, OP_SUB, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, ZERO, ZERO},
      '{MODE_SPARE, OP_SLT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ZERO, ZERO}
   };

   packed_narrow_lane_simd_alu #(.CARRIER_BITS(64)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // returns {compare_bits, result_word}
   function automatic logic [127:0] lane_alu_predict(input logic [MODE_BITS-1:0] mode,
                                                     input logic [OP_BITS-1:0]   op,
                                                     input logic [63:0]          a,
                                                     input logic [63:0]          b);
      int unsigned n;
      int unsigned lanes;
      int unsigned amt;
      int unsigned i;
      logic [3:0]  lm;
      logic [3:0]  hb;
      logic [3:0]  x;
      logic [3:0]  y;
      logic [3:0]  r;
      logic [63:0] word;
      logic [63:0] bits;
      bit          is_cmp;
      bit          hit;
      n     = (mode == LANE_1) ? 1 : (mode == LANE_2) ? 2 : 4;
      lanes = 64 / n;
      lm    = 4'((1 << n) - 1);
      hb    = 4'(1 << (n - 1));
      word  = '0;
      bits  = '0;
      if (op <= OP_SLT) begin
         for (i = 0; i < lanes; i++) begin
            x      = 4'(a >> (i * n)) & lm;
            y      = 4'(b >> (i * n)) & lm;
            r      = '0;
            is_cmp = 1'b0;
            hit    = 1'b0;
            case (op)
               OP_AND:  r = x & y;
               OP_OR:   r = x | y;
               OP_XOR:  r = x ^ y;
               OP_ADD:  r = (x + y) & lm;
               OP_SUB:  r = (x - y) & lm;
               OP_SHL: begin
                  amt = y & (n - 1);
                  r   = (x << amt) & lm;
               end
               OP_LSHR: begin
                  amt = y & (n - 1);
                  r   = x >> amt;
               end
               OP_ASHR: begin
                  amt = (y >= n) ? n - 1 : y;
                  r   = x >> amt;
                  if ((x & hb) != 0) begin
                     r = r | (lm & ~(lm >> amt));
                  end
               end
               OP_EQ: begin
                  is_cmp = 1'b1;
                  hit    = (x == y);
               end
               OP_NE: begin
                  is_cmp = 1'b1;
                  hit    = (x != y);
               end
               OP_ULT: begin
                  is_cmp = 1'b1;
                  hit    = (x < y);
               end
               default: begin
                  is_cmp = 1'b1;
                  hit    = ((x ^ hb) < (y ^ hb));
               end
            endcase
            if (is_cmp) begin
               r       = hit ? lm : 4'd0;
               bits[i] = hit;
            end
            word = word | (64'(r) << (i * n));
         end
      end
      return {bits, word};
   endfunction

   function automatic logic [OP_BITS-1:0] pick_op();
      if ($urandom_range(0, 9) == 0) begin
         return 4'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
      end
      return 4'($urandom_range(int'(OP_AND), int'(OP_SLT)));
   endfunction

   function automatic logic [63:0] pick_operand(input logic [63:0] other);
      case ($urandom_range(0, 7))
         0:       return ZERO;
         1:       return ONES;
         2:       return other;
         3:       return {16{4'($urandom)}};
         4:       return other ^ (64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_op(input logic [OP_BITS-1:0] op, input logic [63:0] a,
                          input logic [63:0] b, input logic [127:0] want);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {b, a};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      pending_lane_results = {pending_lane_results, want};
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lane_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_lane_mode(input logic [MODE_BITS-1:0] mode);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      lane_mode = mode;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result channel sink: random back-pressure plus one long hold
   initial begin : sink_drive
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_tready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            sink_hold         = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (sink_idles && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_lane_results.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            due_result = pending_lane_results.pop_front();
            if (rsp_tdata[63:0] !== due_result[63:0]) begin
               $error("result_word: expected %h, got %h", due_result[63:0], rsp_tdata[63:0]);
               failures++;
            end
            if (rsp_tdata[127:64] !== due_result[127:64]) begin
               $error("compare_bits: expected %h, got %h", due_result[127:64],
                      rsp_tdata[127:64]);
               failures++;
            end
         end
      end
   end

   initial begin : stimulus
      lane_case_type        row;
      logic [MODE_BITS-1:0] mode_seq [4];
      logic [OP_BITS-1:0]   op;
      logic [63:0]          a;
      logic [63:0]          b;
      int unsigned          phase;
      int unsigned          k;
      mode_seq = '{LANE_1, MODE_SPARE, LANE_2, LANE_4};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (lane_cases[i]) begin
         row = lane_cases[i];
         if (row.mode != lane_mode) begin
            drain_results();
            write_lane_mode(row.mode);
         end
         send_op(row.op, row.a, row.b,
                 row.typed ? {row.want_bits, row.want_word}
                           : lane_alu_predict(lane_mode, row.op, row.a, row.b));
      end
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_lane_mode(phase < 4 ? mode_seq[phase] : 2'($urandom_range(0, 3)));
         sender_idles = (phase < PHASES - 2) && ($urandom_range(0, 2) != 0);
         sink_idles   = (phase < PHASES - 2) && ($urandom_range(0, 2) != 0);
         for (k = 0; k < PHASE_OPS; k++) begin
            if (phase == 2 && k == 8) begin
               long_hold_request = 1'b1;
            end
            op = pick_op();
            a  = pick_operand({$urandom, $urandom});
            b  = pick_operand(a);
            send_op(op, a, b, lane_alu_predict(lane_mode, op, a, b));
            if (sender_idles && $urandom_range(0, 3) == 0) begin
               idle_sender($urandom_range(1, 17));
            end
         end
      end
      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
